FILE: rtl/itlm_pkg.sv
package itlm_pkg;

	localparam int LANES = 16;
	localparam int LANE_W = $clog2(LANES);
	localparam int COUNT_W = LANE_W + 1;
	localparam int TILE_W = 24;
	localparam int DIM_W = 13;
	localparam int RPT_W = 5;
	localparam int COORD_W = 12;
	localparam int ERR_W = 2;
	localparam int CFG_IDX_W = 3;

	// quotient bits retired per divider cycle is two
	localparam int DIV_STEPS = TILE_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_TILE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_GROUPS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_GROUPS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT    = 3'd6;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
	localparam logic [ERR_W-1:0] ERR_MASK  = 2'd2;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	// tile coordinates handed to the lane emitter
	typedef struct packed {
		logic [COORD_W-1:0] batch;
		logic [DIM_W-1:0]   hgrp;
		logic [DIM_W-1:0]   wgrp;
		logic               oor;
	} tile_t;

	// settings the lane emitter needs, a zero image width already forced to one
	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] output_height;
		logic [DIM_W-1:0] output_width;
		logic [RPT_W-1:0] rows_per_tile;
	} emit_cfg_t;

endpackage

FILE: rtl/itlm_div.sv
module itlm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [itlm_pkg::TILE_W-1:0]       dividend,
	input  logic [itlm_pkg::DIM_W-1:0]        divisor,
	output logic                              out_valid,
	input  logic                              out_take,
	output logic [itlm_pkg::TILE_W-1:0]       quotient,
	output logic [itlm_pkg::DIM_W-1:0]        remainder
);

	itlm_pkg::div_state_t state_q, state_nxt;
	logic [itlm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [itlm_pkg::TILE_W-1:0]    num_q;
	logic [itlm_pkg::DIM_W-1:0]     rem_q;
	logic [itlm_pkg::DIM_W-1:0]     den_q;
	logic [itlm_pkg::DIM_W:0]       r0, r1;
	logic [itlm_pkg::DIM_W-1:0]     r0_red, r1_red;
	logic                           q0, q1;

	// two restoring steps per cycle
	always_comb begin
		r0 = {rem_q, num_q[itlm_pkg::TILE_W-1]};
		q0 = (r0 >= {1'b0, den_q});
		r0_red = q0 ? itlm_pkg::DIM_W'(r0 - {1'b0, den_q}) : r0[itlm_pkg::DIM_W-1:0];
		r1 = {r0_red, num_q[itlm_pkg::TILE_W-2]};
		q1 = (r1 >= {1'b0, den_q});
		r1_red = q1 ? itlm_pkg::DIM_W'(r1 - {1'b0, den_q}) : r1[itlm_pkg::DIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itlm_pkg::DIV_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			itlm_pkg::DIV_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = itlm_pkg::DIV_RUN;
				end
			end
			itlm_pkg::DIV_RUN: begin
				if (cnt_q == itlm_pkg::DIV_CNT_W'(itlm_pkg::DIV_STEPS - 1)) begin
					state_nxt = itlm_pkg::DIV_DONE;
				end
			end
			itlm_pkg::DIV_DONE: begin
				out_valid = 1'b1;
				if (out_take) begin
					state_nxt = itlm_pkg::DIV_IDLE;
				end
			end
			default: state_nxt = itlm_pkg::DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == itlm_pkg::DIV_IDLE) begin
			cnt_q <= '0;
		end else if (state_q == itlm_pkg::DIV_RUN) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == itlm_pkg::DIV_IDLE && in_valid) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (state_q == itlm_pkg::DIV_RUN) begin
			num_q <= {num_q[itlm_pkg::TILE_W-3:0], q0, q1};
			rem_q <= r1_red;
		end
	end

	assign quotient = num_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/itlm_emit.sv
module itlm_emit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  itlm_pkg::tile_t                    tile,
	input  itlm_pkg::emit_cfg_t                cfg,
	output logic                               result_valid,
	output logic [itlm_pkg::LANE_W-1:0]        lane,
	output logic                               lane_valid,
	output logic [itlm_pkg::COORD_W-1:0]       batch_index,
	output logic [itlm_pkg::COORD_W-1:0]       out_row,
	output logic [itlm_pkg::COORD_W-1:0]       out_col,
	output logic                               last,
	output logic [itlm_pkg::LANES-1:0]         lane_mask,
	output logic [itlm_pkg::COUNT_W-1:0]       valid_count,
	output logic [itlm_pkg::ERR_W-1:0]         error
);

	localparam int BASE_W = itlm_pkg::DIM_W + itlm_pkg::RPT_W;
	localparam int WCOL_W = itlm_pkg::DIM_W + itlm_pkg::LANE_W;

	logic                                active_q;
	logic [itlm_pkg::LANE_W-1:0]         lane_q;
	logic                                oor_q;
	logic [itlm_pkg::COORD_W-1:0]        batch_q;
	logic [itlm_pkg::DIM_W-1:0]          hgrp_q;
	logic [itlm_pkg::DIM_W-1:0]          wgrp_q;
	logic [BASE_W-1:0]                   base_q;
	logic [itlm_pkg::LANE_W-1:0]         lh_q;
	logic [itlm_pkg::LANE_W-1:0]         ow_q;
	logic [itlm_pkg::LANES-1:0]          mask_q;
	logic [itlm_pkg::COUNT_W-1:0]        count_q;

	logic                                load;
	logic                                lane_end;
	logic                                narrow;
	logic [itlm_pkg::DIM_W-1:0]          wm1;
	logic [BASE_W:0]                     oh_n;
	logic [WCOL_W-1:0]                   ow_w;
	logic                                valid;
	logic [itlm_pkg::COORD_W-1:0]        row_c, col_c;
	logic [itlm_pkg::LANES-1:0]          mask_nxt;
	logic [itlm_pkg::COUNT_W-1:0]        count_nxt;
	logic [itlm_pkg::LANES:0]            mask_inc;
	logic                                mask_bad;

	assign lane_end = oor_q || (lane_q == itlm_pkg::LANE_W'(itlm_pkg::LANES - 1));
	assign in_ready = !active_q || lane_end;
	assign load = in_valid && in_ready;

	assign narrow = (cfg.image_width <= itlm_pkg::DIM_W'(itlm_pkg::LANES));
	assign wm1 = cfg.image_width - 1'b1;

	always_comb begin
		oh_n = {1'b0, base_q} + (BASE_W+1)'(lh_q);
		ow_w = {wgrp_q, lane_q};
		if (narrow) begin
			valid = ({1'b0, lh_q} < cfg.rows_per_tile)
				&& (oh_n < (BASE_W+1)'(cfg.output_height))
				&& (itlm_pkg::DIM_W'(ow_q) < cfg.output_width);
			row_c = oh_n[itlm_pkg::COORD_W-1:0];
			col_c = itlm_pkg::COORD_W'(ow_q);
		end else begin
			valid = (hgrp_q < cfg.output_height) && (ow_w < WCOL_W'(cfg.output_width));
			row_c = hgrp_q[itlm_pkg::COORD_W-1:0];
			col_c = ow_w[itlm_pkg::COORD_W-1:0];
		end
		mask_nxt = mask_q | (itlm_pkg::LANES'(valid) << lane_q);
		count_nxt = count_q + itlm_pkg::COUNT_W'(valid);
		mask_inc = {1'b0, mask_nxt} + 1'b1;
		mask_bad = (mask_nxt == '0) || ((mask_nxt & mask_inc[itlm_pkg::LANES-1:0]) != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (active_q && lane_end) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lane_q <= '0;
			lh_q <= '0;
			ow_q <= '0;
			mask_q <= '0;
			count_q <= '0;
			oor_q <= tile.oor;
			batch_q <= tile.batch;
			hgrp_q <= tile.hgrp;
			wgrp_q <= tile.wgrp;
			base_q <= BASE_W'(tile.hgrp) * BASE_W'(cfg.rows_per_tile);
		end else if (active_q) begin
			lane_q <= lane_q + 1'b1;
			mask_q <= mask_nxt;
			count_q <= count_nxt;
			if (ow_q == wm1[itlm_pkg::LANE_W-1:0]) begin
				ow_q <= '0;
				lh_q <= lh_q + 1'b1;
			end else begin
				ow_q <= ow_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (oor_q) begin
			lane <= '0;
			lane_valid <= 1'b0;
			batch_index <= '0;
			out_row <= '0;
			out_col <= '0;
			last <= 1'b1;
			lane_mask <= '0;
			valid_count <= '0;
			error <= itlm_pkg::ERR_RANGE;
		end else begin
			lane <= lane_q;
			lane_valid <= valid;
			batch_index <= valid ? batch_q : '0;
			out_row <= valid ? row_c : '0;
			out_col <= valid ? col_c : '0;
			last <= lane_end;
			lane_mask <= lane_end ? mask_nxt : '0;
			valid_count <= lane_end ? count_nxt : '0;
			error <= (lane_end && mask_bad) ? itlm_pkg::ERR_MASK : itlm_pkg::ERR_OK;
		end
	end

endmodule

FILE: rtl/im2col_tile_lane_mapper.sv
// im2col tile lane mapper: turns a tile index into per-lane output positions
// for a 16-lane systolic array
// input: tile_number is taken at a clock edge with start high and busy low
// config: cfg_valid/cfg_ready write channel, cfg_index picks the register,
//   cfg_data holds the value; cfg_ready is always high, write only when idle
// output: one word per cycle with result_valid high; sixteen words per tile,
//   lanes 0 to 15, the last one carrying lane_mask, valid_count and error;
//   an out-of-range tile gives a single word with error set
// dividers: each quotient/remainder step holds a radix-4 divider through
//   load, 12 two-bit steps and hand-off
// throughput: the tile rate is set by the lane emitter sending one word per
//   cycle while it holds a tile; the dividers run ahead on the following
//   tiles; runs of out-of-range tiles go at the divider pace, as a divider
//   takes a new tile only after it has handed off the last one
// busy: high while the first divider holds a tile
// reset: all pipeline stages empty, configuration registers back to their defaults
// the receiver cannot stall: every word is shown for exactly one cycle
module im2col_tile_lane_mapper (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [itlm_pkg::TILE_W-1:0]        tile_number,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [itlm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [itlm_pkg::TILE_W-1:0]        cfg_data,
	output logic                               result_valid,
	output logic [itlm_pkg::LANE_W-1:0]        lane,
	output logic                               lane_valid,
	output logic [itlm_pkg::COORD_W-1:0]       batch_index,
	output logic [itlm_pkg::COORD_W-1:0]       out_row,
	output logic [itlm_pkg::COORD_W-1:0]       out_col,
	output logic                               last,
	output logic [itlm_pkg::LANES-1:0]         lane_mask,
	output logic [itlm_pkg::COUNT_W-1:0]       valid_count,
	output logic [itlm_pkg::ERR_W-1:0]         error
);

	// configuration registers
	logic [itlm_pkg::DIM_W-1:0]  image_width_q;
	logic [itlm_pkg::DIM_W-1:0]  output_height_q;
	logic [itlm_pkg::DIM_W-1:0]  output_width_q;
	logic [itlm_pkg::RPT_W-1:0]  rows_per_tile_q;
	logic [itlm_pkg::DIM_W-1:0]  row_groups_q;
	logic [itlm_pkg::DIM_W-1:0]  column_groups_q;
	logic [itlm_pkg::TILE_W-1:0] tile_count_q;

	// zero group counts and a zero image width behave as one
	logic [itlm_pkg::DIM_W-1:0] rg1, cg1, w1;

	logic                          a_ready, a_out_valid, a_take;
	logic [itlm_pkg::TILE_W-1:0]   a_quot;
	logic [itlm_pkg::DIM_W-1:0]    a_rem;
	logic                          b_ready, b_out_valid, b_take;
	logic [itlm_pkg::TILE_W-1:0]   b_quot;
	logic [itlm_pkg::DIM_W-1:0]    b_rem;
	logic                          accept;
	logic                          a_to_b;

	// sideband that rides along with each divider
	logic                          oor_s1;
	logic                          oor_s2;
	logic [itlm_pkg::DIM_W-1:0]    wgrp_s2;

	itlm_pkg::tile_t     tile;
	itlm_pkg::emit_cfg_t ecfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= itlm_pkg::DIM_W'(1);
			output_height_q <= itlm_pkg::DIM_W'(1);
			output_width_q <= itlm_pkg::DIM_W'(1);
			rows_per_tile_q <= itlm_pkg::RPT_W'(1);
			row_groups_q <= itlm_pkg::DIM_W'(1);
			column_groups_q <= itlm_pkg::DIM_W'(1);
			tile_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				itlm_pkg::REG_IMAGE_WIDTH:   image_width_q <= cfg_data[itlm_pkg::DIM_W-1:0];
				itlm_pkg::REG_OUTPUT_HEIGHT: output_height_q <= cfg_data[itlm_pkg::DIM_W-1:0];
				itlm_pkg::REG_OUTPUT_WIDTH:  output_width_q <= cfg_data[itlm_pkg::DIM_W-1:0];
				itlm_pkg::REG_ROWS_PER_TILE: rows_per_tile_q <= cfg_data[itlm_pkg::RPT_W-1:0];
				itlm_pkg::REG_ROW_GROUPS:    row_groups_q <= cfg_data[itlm_pkg::DIM_W-1:0];
				itlm_pkg::REG_COLUMN_GROUPS: column_groups_q <= cfg_data[itlm_pkg::DIM_W-1:0];
				itlm_pkg::REG_TILE_COUNT:    tile_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rg1 = (row_groups_q == '0) ? itlm_pkg::DIM_W'(1) : row_groups_q;
	assign cg1 = (column_groups_q == '0) ? itlm_pkg::DIM_W'(1) : column_groups_q;
	assign w1 = (image_width_q == '0) ? itlm_pkg::DIM_W'(1) : image_width_q;

	assign busy = !a_ready;
	assign accept = start && a_ready;

	// first divide: tile / column_groups gives column group and a partial index
	itlm_div u_div_col (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_ready  (a_ready),
		.dividend  (tile_number),
		.divisor   (cg1),
		.out_valid (a_out_valid),
		.out_take  (a_take),
		.quotient  (a_quot),
		.remainder (a_rem)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			oor_s1 <= (tile_number >= tile_count_q);
		end
	end

	assign a_take = b_ready;
	assign a_to_b = a_out_valid && b_ready;

	// second divide: that index / row_groups gives batch and row group
	itlm_div u_div_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_out_valid),
		.in_ready  (b_ready),
		.dividend  (a_quot),
		.divisor   (rg1),
		.out_valid (b_out_valid),
		.out_take  (b_take),
		.quotient  (b_quot),
		.remainder (b_rem)
	);

	always_ff @(posedge clk) begin
		if (a_to_b) begin
			oor_s2 <= oor_s1;
			wgrp_s2 <= a_rem;
		end
	end

	assign tile.batch = b_quot[itlm_pkg::COORD_W-1:0];
	assign tile.hgrp = b_rem;
	assign tile.wgrp = wgrp_s2;
	assign tile.oor = oor_s2;

	assign ecfg.image_width = w1;
	assign ecfg.output_height = output_height_q;
	assign ecfg.output_width = output_width_q;
	assign ecfg.rows_per_tile = rows_per_tile_q;

	// lane emitter: one word per lane, final word gets mask, count and error
	itlm_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (b_out_valid),
		.in_ready     (b_take),
		.tile         (tile),
		.cfg          (ecfg),
		.result_valid (result_valid),
		.lane         (lane),
		.lane_valid   (lane_valid),
		.batch_index  (batch_index),
		.out_row      (out_row),
		.out_col      (out_col),
		.last         (last),
		.lane_mask    (lane_mask),
		.valid_count  (valid_count),
		.error        (error)
	);

endmodule
